// File: hw/rtl/slc_pkg.sv
package slc_pkg;

   localparam int CH_WIDTH    = 8;
   localparam int CLASS_WIDTH = 3;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int WINDOW_DEPTH = 3;

   // Line classes
   localparam logic [CLASS_WIDTH-1:0] CLASS_BLANK            = 3'd0;
   localparam logic [CLASS_WIDTH-1:0] CLASS_BLANK_IN_COMMENT = 3'd1;
   localparam logic [CLASS_WIDTH-1:0] CLASS_CODE             = 3'd2;
   localparam logic [CLASS_WIDTH-1:0] CLASS_COMMENT          = 3'd3;
   localparam logic [CLASS_WIDTH-1:0] CLASS_CODE_COMMENT     = 3'd4;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_COMMENTS = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_BLANKS   = 2'd1;

   // Characters that steer the scan
   localparam logic [CH_WIDTH-1:0] CH_QUOTE     = 8'h27;
   localparam logic [CH_WIDTH-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [CH_WIDTH-1:0] CH_DQUOTE    = 8'h22;
   localparam logic [CH_WIDTH-1:0] CH_SLASH     = 8'h2F;
   localparam logic [CH_WIDTH-1:0] CH_STAR      = 8'h2A;
   localparam logic [CH_WIDTH-1:0] CH_SPACE     = 8'h20;
   localparam logic [CH_WIDTH-1:0] CH_TAB       = 8'h09;
   localparam logic [CH_WIDTH-1:0] CH_CR        = 8'h0D;

   typedef logic [WINDOW_DEPTH-1:0][CH_WIDTH-1:0] window_type;
   typedef logic [WINDOW_DEPTH:0][CH_WIDTH-1:0]   scan_buf_type;

   typedef struct packed {
      logic in_block;
      logic in_quote;
      logic has_code;
      logic has_comment;
      logic rest_ignored;
   } scan_type;

   typedef struct packed {
      scan_type   st;
      logic [2:0] used;
   } head_result_type;

   function automatic logic is_blank_char(input logic [CH_WIDTH-1:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   // Decide the head character of chars; n counts valid entries (1..4).
   function automatic head_result_type slc_head(input scan_type st,
                                                input scan_buf_type chars,
                                                input logic [2:0] n,
                                                input logic ends,
                                                input logic pc);
      head_result_type res;
      logic [CH_WIDTH-1:0] c;
      logic [CH_WIDTH-1:0] nx;
      logic free_text;
      logic bslash;
      logic closing;
      res.st   = st;
      res.used = 3'd1;
      c         = chars[0];
      nx        = (n > 3'd1) ? chars[1] : '0;
      free_text = !st.in_block && !st.in_quote;
      bslash    = (chars[1] == CH_BACKSLASH);
      closing   = bslash ? (chars[3] == CH_QUOTE) : (chars[2] == CH_QUOTE);
      if (c == CH_SLASH && nx == CH_SLASH && free_text && pc) begin
         res.st.has_comment  = 1'b1;
         res.st.rest_ignored = 1'b1;
         res.used            = n;
      end else if (free_text && c == CH_QUOTE) begin
         res.st.has_code = 1'b1;
         // literal runs into the line end: drop the rest of the line
         if (ends && (bslash || n <= 3'd3)) begin
            res.st.rest_ignored = 1'b1;
            res.used            = n;
         end else if (closing) begin
            res.used = bslash ? 3'd4 : 3'd3;
         end else begin
            res.used = 3'd1;
         end
      end else if (c == CH_SLASH && nx == CH_STAR && free_text && pc) begin
         res.st.in_block    = 1'b1;
         res.st.has_comment = 1'b1;
         res.used           = 3'd2;
      end else if (c == CH_STAR && nx == CH_SLASH && st.in_block && !st.in_quote && pc) begin
         res.st.in_block = 1'b0;
         res.used        = 3'd2;
      end else if (c == CH_BACKSLASH && !st.in_block) begin
         res.st.has_code = 1'b1;
         res.used        = 3'd2;
      end else if (c == CH_DQUOTE && !st.in_block) begin
         res.st.in_quote = !st.in_quote;
         res.st.has_code = 1'b1;
      end else if (!st.in_block && !is_blank_char(c)) begin
         res.st.has_code = 1'b1;
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/slc_ifs.sv
interface slc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [slc_pkg::CH_WIDTH-1:0]  ch;
   logic                          last;
   modport source (output valid, kind, ch, last, input ready);
   modport sink (input valid, kind, ch, last, output ready);
endinterface

interface slc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [slc_pkg::CLASS_WIDTH-1:0]  line_class;
   logic                             still_in_comment;
   modport source (output valid, line_class, still_in_comment, input ready);
   modport sink (input valid, line_class, still_in_comment, output ready);
endinterface

interface slc_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [slc_pkg::CSR_INDEX_WIDTH-1:0]  index;
   logic                                 data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/slc_scan.sv
module slc_scan (
   input  slc_pkg::scan_type            st_cur,
   input  slc_pkg::window_type          window_cur,
   input  logic [1:0]                   fill_cur,
   input  logic [slc_pkg::CH_WIDTH-1:0] ch,
   input  logic                         ends,
   input  logic                         pc,
   output slc_pkg::scan_type            st_nxt,
   output slc_pkg::window_type          window_nxt,
   output logic [1:0]                   fill_nxt
);
   import slc_pkg::*;

   always_comb begin : scan_pass
      scan_type        st;
      scan_buf_type    buf_q;
      logic [2:0]      n;
      head_result_type res;
      st    = st_cur;
      buf_q = {{CH_WIDTH{1'b0}}, window_cur};
      buf_q[fill_cur] = ch;
      n     = {1'b0, fill_cur} + 3'd1;
      res   = '0;
      if (st_cur.rest_ignored) begin
         n = 3'd0;
      end else begin
         // each pass consumes at least one character, so four passes empty a full buffer at a line end
         for (int i = 0; i < WINDOW_DEPTH + 1; i++) begin
            if (n != 3'd0 && !st.rest_ignored && (n == 3'd4 || ends)) begin
               res = slc_head(st, buf_q, n, ends, pc);
               st  = res.st;
               if (res.used >= n) begin
                  n = 3'd0;
               end else begin
                  case (res.used)
                     3'd1: buf_q = {{CH_WIDTH{1'b0}}, buf_q[3:1]};
                     3'd2: buf_q = {{2*CH_WIDTH{1'b0}}, buf_q[3:2]};
                     3'd3: buf_q = {{3*CH_WIDTH{1'b0}}, buf_q[3]};
                     default: buf_q = buf_q;
                  endcase
                  n = n - res.used;
               end
            end
         end
         if (st.rest_ignored) begin
            n = 3'd0;
         end
      end
      st_nxt     = st;
      window_nxt = buf_q[2:0];
      // at most three characters remain pending after the pass
      fill_nxt   = n[1:0];
   end

endmodule

// File: hw/rtl/source_line_classifier.sv
// Channel | Dir | Payload                         | Transfer
// --------+-----+---------------------------------+---------------------------
// req     | in  | kind, ch[7:0], last             | valid && ready
// rsp     | out | line_class[2:0], still_in_comment | valid && ready
// csr     | in  | index[1:0], data                | valid && ready (always ready)
//
// One character enters per cycle unless a stalled rsp holds back a line end. A
// request passes the input register and one combinational scan pass; its line
// result (at a line end or an empty-line marker) lands in the output register.
// Reset is synchronous and active high; both settings come back as 1.
// A stalled rsp holds only requests that end a line; mid-line characters keep
// flowing while a result waits.
module source_line_classifier (
   input  logic      clock,
   input  logic      reset,
   slc_req_if.sink   req_chan,
   slc_rsp_if.source rsp_chan,
   slc_csr_if.sink   csr_chan
);
   import slc_pkg::*;

   // input register
   logic                s1_valid_ff, s1_valid_in;
   logic                s1_kind_ff, s1_kind_in;
   logic [CH_WIDTH-1:0] s1_ch_ff, s1_ch_in;
   logic                s1_last_ff, s1_last_in;

   // line scanner state
   scan_type   st_ff, st_in;
   window_type window_ff, window_in;
   logic [1:0] fill_ff, fill_in;

   // settings
   logic pc_ff, pc_in;
   logic pb_ff, pb_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CLASS_WIDTH-1:0] rsp_class_ff, rsp_class_in;
   logic                   rsp_still_ff, rsp_still_in;

   scan_type   scan_st;
   window_type scan_window;
   logic [1:0] scan_fill;

   logic s1_has_result;
   logic out_free;
   logic s1_fire;
   logic req_take;

   slc_scan u_scan (
      .st_cur     (st_ff),
      .window_cur (window_ff),
      .fill_cur   (fill_ff),
      .ch         (s1_ch_ff),
      .ends       (s1_last_ff),
      .pc         (pc_ff),
      .st_nxt     (scan_st),
      .window_nxt (scan_window),
      .fill_nxt   (scan_fill)
   );

   // A request ends a line when it is a marker or carries last.
   assign s1_has_result = s1_kind_ff || s1_last_ff;
   assign out_free      = !rsp_valid_ff || rsp_chan.ready;
   // Advance the held request unless its result has nowhere to go.
   assign s1_fire       = s1_valid_ff && (!s1_has_result || out_free);
   assign req_chan.ready = !s1_valid_ff || s1_fire;
   assign req_take      = req_chan.valid && req_chan.ready;

   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.line_class       = rsp_class_ff;
   assign rsp_chan.still_in_comment = rsp_still_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_kind_in  = s1_kind_ff;
      s1_ch_in    = s1_ch_ff;
      s1_last_in  = s1_last_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = req_chan.kind;
         s1_ch_in    = req_chan.ch;
         s1_last_in  = req_chan.last;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      pc_in = pc_ff;
      pb_in = pb_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PROCESS_COMMENTS: pc_in = csr_chan.data;
            CSR_PROCESS_BLANKS:   pb_in = csr_chan.data;
            default: ;
         endcase
      end
   end

   // Scanner state and result.
   always_comb begin
      st_in        = st_ff;
      window_in    = window_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_class_in = rsp_class_ff;
      rsp_still_in = rsp_still_ff;
      if (s1_fire) begin
         if (s1_kind_ff) begin
            // empty line: drop any partial line, report the block state
            rsp_valid_in = 1'b1;
            rsp_class_in = st_ff.in_block ? CLASS_BLANK_IN_COMMENT : CLASS_BLANK;
            rsp_still_in = st_ff.in_block;
         end else if (s1_last_ff) begin
            rsp_valid_in = 1'b1;
            rsp_still_in = scan_st.in_block;
            if (scan_st.has_code && scan_st.has_comment) begin
               rsp_class_in = CLASS_CODE_COMMENT;
            end else if (scan_st.has_comment) begin
               rsp_class_in = CLASS_COMMENT;
            end else if (scan_st.has_code) begin
               rsp_class_in = CLASS_CODE;
            end else begin
               rsp_class_in = pb_ff ? CLASS_BLANK : CLASS_CODE;
            end
         end else begin
            st_in     = scan_st;
            window_in = scan_window;
            fill_in   = scan_fill;
         end
         if (s1_has_result) begin
            // start the next line; an open block comment marks it as comment
            st_in.in_block     = s1_kind_ff ? st_ff.in_block : scan_st.in_block;
            st_in.in_quote     = 1'b0;
            st_in.has_code     = 1'b0;
            st_in.has_comment  = st_in.in_block;
            st_in.rest_ignored = 1'b0;
            fill_in            = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         st_ff        <= '0;
         fill_ff      <= 2'd0;
         pc_ff        <= 1'b1;
         pb_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         st_ff        <= st_in;
         fill_ff      <= fill_in;
         pc_ff        <= pc_in;
         pb_ff        <= pb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      s1_kind_ff   <= s1_kind_in;
      s1_ch_ff     <= s1_ch_in;
      s1_last_ff   <= s1_last_in;
      window_ff    <= window_in;
      rsp_class_ff <= rsp_class_in;
      rsp_still_ff <= rsp_still_in;
   end

endmodule
